// ----- src/prewitt_pkg.sv -----
// shared types, constants and helper functions of the prewitt edge magnitude block
package prewitt_pkg;

   // field widths
   localparam int CHANNEL_W     = 8;
   localparam int INTENSITY_W   = 10;
   localparam int LINE_LENGTH_W = 12;
   localparam int LINE_COUNT_W  = 16;
   localparam int LINE_INDEX_W  = LINE_COUNT_W + 1;
   localparam int GRAD_W        = 13;
   localparam int ABS_W         = GRAD_W - 1;
   localparam int MAG_W         = 11;
   localparam int MAG_MAX       = 1081;
   localparam int WIN           = 3;

   // port widths
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 3 * CHANNEL_W;
   localparam int RSP_DATA_W  = 16;

   // register reset values and the default line buffer size
   localparam int MAX_LINE_LENGTH_DEFAULT = 2048;
   localparam logic [LINE_LENGTH_W-1:0] LINE_LENGTH_RESET = 12'd640;
   localparam logic [LINE_COUNT_W-1:0]  LINE_COUNT_RESET  = 16'd480;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // square root and divide by three
   localparam int SQ_W        = 25;
   localparam int SQRT_STEPS  = 12;
   localparam int ROOT_W      = 12;
   localparam int DIV3_SHIFT  = 13;
   localparam int DIV3_W      = 12;
   localparam logic [DIV3_W-1:0] DIV3_RECIP = 12'd2731;
   localparam int PROD_W      = ROOT_W + DIV3_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_LENGTH = 4'd0,
      CSR_LINE_COUNT  = 4'd1
   } csr_index_type;

   typedef enum logic {
      ACTION_PIXEL = 1'b0,
      ACTION_DRAIN = 1'b1
   } action_type;

   // one gradient item handed from front to back
   typedef struct packed {
      logic signed [GRAD_W-1:0] gx;
      logic signed [GRAD_W-1:0] gy;
      logic                     frame_end;
   } grad_type;

   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [SQ_W-1:0] root;
   } sqrt_step_type;

   // 0 acts as 1, anything above the buffer size acts as the buffer size
   function automatic logic [31:0] clamp_length(input logic [LINE_LENGTH_W-1:0] ll,
                                                input int unsigned max_len);
      logic [31:0] r;
      if (ll == '0) begin
         r = 32'd1;
      end else if (32'(ll) > max_len) begin
         r = max_len;
      end else begin
         r = 32'(ll);
      end
      return r;
   endfunction

   // one digit of the restoring square root
   function automatic sqrt_step_type sqrt_step(input logic [SQ_W-1:0] rem,
                                               input logic [SQ_W-1:0] root,
                                               input logic [SQ_W-1:0] bitv);
      sqrt_step_type r;
      logic [SQ_W-1:0] trial;
      trial = root + bitv;
      if (rem >= trial) begin
         r.rem  = rem - trial;
         r.root = (root >> 1) + bitv;
      end else begin
         r.rem  = rem;
         r.root = root >> 1;
      end
      return r;
   endfunction

endpackage

// ----- src/prewitt_queue.sv -----
// small register queue carrying gradient items from the front to the back
module prewitt_queue import prewitt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  grad_type            push_data,
   input  logic                pop,
   output grad_type            pop_data,
   output logic                empty,
   output logic [QCOUNT_W-1:0] count
);

   grad_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

// ----- src/prewitt_front.sv -----
// front: frame position tracking, line buffers, 3x3 window and masked prewitt sums
module prewitt_front import prewitt_pkg::*; #(
   parameter int MAX_LINE_LENGTH = MAX_LINE_LENGTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_action,
   input  logic [CHANNEL_W-1:0]   req_red,
   input  logic [CHANNEL_W-1:0]   req_green,
   input  logic [CHANNEL_W-1:0]   req_blue,
   input  logic [QCOUNT_W-1:0]    q_count,
   output logic                   q_push,
   output grad_type               q_push_data
);

   localparam int XW = $clog2(MAX_LINE_LENGTH);
   localparam int DW = 2 * INTENSITY_W;

   // configuration, kept as effective values
   logic [XW-1:0]           len_last_ff, len_last_in;
   logic [LINE_INDEX_W-1:0] cnt_ff, cnt_in;
   logic [LINE_INDEX_W-1:0] cnt_p1_ff, cnt_p1_in;
   logic                    cfg_len_wr, cfg_cnt_wr, restart;
   logic [31:0]             len_full;
   logic [LINE_INDEX_W-1:0] cnt_full;

   // position of the next pixel
   logic [XW-1:0]           x_ff, x_in;
   logic [LINE_INDEX_W-1:0] y_ff, y_in;

   logic                    take, draining, xnz, produce, frame_done;
   logic                    ox_first, ox_last, oy_first, oy_last;
   logic [INTENSITY_W-1:0]  intensity;

   // item in the window stage
   logic                    valid_a_ff, valid_a_in;
   logic [INTENSITY_W-1:0]  s_a_ff;
   logic [XW-1:0]           x_a_ff;
   logic                    produce_a_ff, fe_a_ff;
   logic                    ox_first_a_ff, ox_last_a_ff, oy_first_a_ff, oy_last_a_ff;

   // line buffer, one word holds both stored lines at a position
   logic [DW-1:0]           line_mem [MAX_LINE_LENGTH];
   logic [DW-1:0]           mem_rd_ff;
   logic [DW-1:0]           byp_data_ff;
   logic                    byp_ff;
   logic [DW-1:0]           rd_word, wr_data;
   logic [INTENSITY_W-1:0]  col [WIN];

   logic [INTENSITY_W-1:0]  win_ff [WIN][WIN];
   logic [INTENSITY_W-1:0]  win_in [WIN][WIN];
   logic [INTENSITY_W-1:0]  win_sh [WIN][WIN];
   logic [INTENSITY_W-1:0]  tap    [WIN][WIN];
   logic                    row_ok [WIN];
   logic                    col_ok [WIN];
   logic [ABS_W-1:0]        sum_right, sum_left, sum_top, sum_bottom;

   // configuration decode
   always_comb begin
      cfg_len_wr  = csr_valid && (csr_index == CSR_LINE_LENGTH);
      cfg_cnt_wr  = csr_valid && (csr_index == CSR_LINE_COUNT);
      restart     = cfg_len_wr || cfg_cnt_wr;
      len_full    = clamp_length(csr_data[LINE_LENGTH_W-1:0], MAX_LINE_LENGTH);
      cnt_full    = LINE_INDEX_W'(csr_data[LINE_COUNT_W-1:0]);
      if (cnt_full == '0) begin
         cnt_full = LINE_INDEX_W'(1);
      end
      len_last_in = cfg_len_wr ? XW'(len_full - 32'd1) : len_last_ff;
      cnt_in      = cfg_cnt_wr ? cnt_full : cnt_ff;
      cnt_p1_in   = cfg_cnt_wr ? cnt_full + 1'b1 : cnt_p1_ff;
   end

   // classify the item at the input
   always_comb begin
      draining   = (y_ff >= cnt_ff);
      take       = req_valid && req_ready && (draining || req_action == ACTION_PIXEL);
      intensity  = draining ? '0 : INTENSITY_W'(req_red) + INTENSITY_W'(req_green)
                                   + INTENSITY_W'(req_blue);
      xnz        = (x_ff != '0);
      produce    = (y_ff >= LINE_INDEX_W'(2)) || (y_ff == LINE_INDEX_W'(1) && xnz);
      // the window center trails the input by one line and one pixel
      ox_first   = xnz ? (x_ff == XW'(1)) : (len_last_ff == '0);
      ox_last    = !xnz;
      oy_first   = xnz ? (y_ff == LINE_INDEX_W'(1)) : (y_ff == LINE_INDEX_W'(2));
      oy_last    = xnz ? (y_ff == cnt_ff) : (y_ff == cnt_p1_ff);
      frame_done = produce && ox_last && oy_last;

      x_in = x_ff;
      y_in = y_ff;
      if (restart) begin
         x_in = '0;
         y_in = '0;
      end else if (take) begin
         if (frame_done) begin
            x_in = '0;
            y_in = '0;
         end else if (x_ff == len_last_ff) begin
            x_in = '0;
            y_in = y_ff + 1'b1;
         end else begin
            x_in = x_ff + 1'b1;
         end
      end
      valid_a_in = take;
   end

   // an item in flight in the window stage must always find room in the queue
   assign req_ready = ((QCOUNT_W + 1)'(q_count) + (QCOUNT_W + 1)'(valid_a_ff))
                      < (QCOUNT_W + 1)'(QUEUE_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_last_ff <= XW'(clamp_length(LINE_LENGTH_RESET, MAX_LINE_LENGTH) - 32'd1);
         cnt_ff      <= LINE_INDEX_W'(LINE_COUNT_RESET);
         cnt_p1_ff   <= LINE_INDEX_W'(LINE_COUNT_RESET) + 1'b1;
         x_ff        <= '0;
         y_ff        <= '0;
         valid_a_ff  <= 1'b0;
      end else begin
         len_last_ff <= len_last_in;
         cnt_ff      <= cnt_in;
         cnt_p1_ff   <= cnt_p1_in;
         x_ff        <= x_in;
         y_ff        <= y_in;
         valid_a_ff  <= valid_a_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s_a_ff        <= intensity;
         x_a_ff        <= x_ff;
         produce_a_ff  <= produce;
         fe_a_ff       <= frame_done;
         ox_first_a_ff <= ox_first;
         ox_last_a_ff  <= ox_last;
         oy_first_a_ff <= oy_first;
         oy_last_a_ff  <= oy_last;
         // a write to the same position in this cycle is not seen by the read
         byp_ff        <= valid_a_ff && (x_a_ff == x_ff);
         byp_data_ff   <= wr_data;
      end
   end

   // line buffer: read at accept, written back on the following edge
   always_ff @(posedge clock) begin
      if (valid_a_ff) begin
         line_mem[x_a_ff] <= wr_data;
      end
      if (take) begin
         mem_rd_ff <= line_mem[x_ff];
      end
   end

   always_comb begin
      rd_word = byp_ff ? byp_data_ff : mem_rd_ff;
      col[0]  = rd_word[INTENSITY_W-1:0];
      col[1]  = rd_word[DW-1:INTENSITY_W];
      col[2]  = s_a_ff;
      wr_data = {s_a_ff, col[1]};
   end

   // window shift and border masking
   always_comb begin
      row_ok[0] = !oy_first_a_ff;
      row_ok[1] = 1'b1;
      row_ok[2] = !oy_last_a_ff;
      col_ok[0] = !ox_first_a_ff;
      col_ok[1] = 1'b1;
      col_ok[2] = !ox_last_a_ff;
      for (int r = 0; r < WIN; r++) begin
         win_sh[r][0] = win_ff[r][1];
         win_sh[r][1] = win_ff[r][2];
         win_sh[r][2] = col[r];
         for (int c = 0; c < WIN; c++) begin
            tap[r][c] = (row_ok[r] && col_ok[c]) ? win_sh[r][c] : '0;
         end
      end
      sum_right  = '0;
      sum_left   = '0;
      sum_top    = '0;
      sum_bottom = '0;
      for (int k = 0; k < WIN; k++) begin
         sum_right  = sum_right  + ABS_W'(tap[k][2]);
         sum_left   = sum_left   + ABS_W'(tap[k][0]);
         sum_top    = sum_top    + ABS_W'(tap[0][k]);
         sum_bottom = sum_bottom + ABS_W'(tap[2][k]);
      end
      for (int r = 0; r < WIN; r++) begin
         for (int c = 0; c < WIN; c++) begin
            win_in[r][c] = win_ff[r][c];
            if (restart || (valid_a_ff && fe_a_ff)) begin
               win_in[r][c] = '0;
            end else if (valid_a_ff) begin
               win_in[r][c] = win_sh[r][c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < WIN; r++) begin
            for (int c = 0; c < WIN; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         win_ff <= win_in;
      end
   end

   always_comb begin
      q_push                = valid_a_ff && produce_a_ff;
      q_push_data.gx        = $signed(GRAD_W'(sum_right)) - $signed(GRAD_W'(sum_left));
      q_push_data.gy        = $signed(GRAD_W'(sum_top)) - $signed(GRAD_W'(sum_bottom));
      q_push_data.frame_end = fe_a_ff;
   end

endmodule

// ----- src/prewitt_back.sv -----
// back: squares, pipelined square root, divide by three and the result register
module prewitt_back import prewitt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  grad_type         q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [MAG_W-1:0] rsp_magnitude,
   output logic             rsp_frame_end
);

   logic                    advance;

   logic                    v_abs_ff, fe_abs_ff;
   logic [ABS_W-1:0]        ax_ff, ay_ff;
   logic                    v_sq_ff, fe_sq_ff;
   logic [2*ABS_W-1:0]      sqx_ff, sqy_ff;

   logic                    v_rt_ff  [SQRT_STEPS+1];
   logic                    fe_rt_ff [SQRT_STEPS+1];
   logic [SQ_W-1:0]         rem_ff   [SQRT_STEPS+1];
   logic [SQ_W-1:0]         root_ff  [SQRT_STEPS+1];

   logic                    v_prod_ff, fe_prod_ff;
   logic [PROD_W-1:0]       prod_ff;

   logic                    out_valid_ff;
   logic [MAG_W-1:0]        out_mag_ff;
   logic                    out_fe_ff;

   // the whole pipe holds while a result waits at the output
   assign advance = !out_valid_ff || rsp_ready;
   assign q_pop   = advance && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_abs_ff     <= 1'b0;
         v_sq_ff      <= 1'b0;
         v_rt_ff[0]   <= 1'b0;
         v_prod_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         v_abs_ff     <= !q_empty;
         v_sq_ff      <= v_abs_ff;
         v_rt_ff[0]   <= v_sq_ff;
         v_prod_ff    <= v_rt_ff[SQRT_STEPS];
         out_valid_ff <= v_prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ax_ff       <= q_data.gx[GRAD_W-1] ? ABS_W'(-q_data.gx) : ABS_W'(q_data.gx);
         ay_ff       <= q_data.gy[GRAD_W-1] ? ABS_W'(-q_data.gy) : ABS_W'(q_data.gy);
         fe_abs_ff   <= q_data.frame_end;
         sqx_ff      <= ax_ff * ax_ff;
         sqy_ff      <= ay_ff * ay_ff;
         fe_sq_ff    <= fe_abs_ff;
         rem_ff[0]   <= SQ_W'(sqx_ff) + SQ_W'(sqy_ff);
         root_ff[0]  <= '0;
         fe_rt_ff[0] <= fe_sq_ff;
         prod_ff     <= root_ff[SQRT_STEPS][ROOT_W-1:0] * DIV3_RECIP;
         fe_prod_ff  <= fe_rt_ff[SQRT_STEPS];
         out_mag_ff  <= prod_ff[DIV3_SHIFT +: MAG_W];
         out_fe_ff   <= fe_prod_ff;
      end
   end

   // one result bit per stage, highest first
   for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [SQ_W-1:0] StepBit = SQ_W'(1) << (2 * (SQRT_STEPS - k));
      sqrt_step_type step;

      assign step = sqrt_step(rem_ff[k-1], root_ff[k-1], StepBit);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_rt_ff[k] <= 1'b0;
         end else if (advance) begin
            v_rt_ff[k] <= v_rt_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]   <= step.rem;
            root_ff[k]  <= step.root;
            fe_rt_ff[k] <= fe_rt_ff[k-1];
         end
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_magnitude = out_mag_ff;
   assign rsp_frame_end = out_fe_ff;

endmodule

// ----- src/prewitt_edge_magnitude.sv -----
// Prewitt edge magnitude over a streamed RGB frame, 3x3 window with zero padding.
// Pixels come in line by line; the block sustains one pixel or drain item per cycle
// while the result side keeps up and the queue has room. The front reads and writes
// back the two-line buffer (MAX_LINE_LENGTH words of two intensities) once per item and
// forms the masked gradients; a four-entry queue decouples it from the back, which
// squares, takes a 12-stage pipelined square root and divides by three. A result passes
// the window stage, the queue and the abs, square, root, product and output registers, and
// results trail the pixels by one line plus one pixel, so after the last pixel of a frame
// send drain items (tuser set) until the result with tlast comes out. A drain before the
// frame is complete is dropped, a pixel after it counts as a drain. Writing either
// register restarts the frame. The line buffer needs no clearing after reset: border
// masking hides every entry that the current frame has not yet written.
module prewitt_edge_magnitude import prewitt_pkg::*; #(
   parameter int MAX_LINE_LENGTH = MAX_LINE_LENGTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,  // red, green, blue
   input  logic                   req_tuser,  // action
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,  // magnitude
   output logic                   rsp_tlast
);

   logic                q_push, q_pop, q_empty;
   grad_type            q_push_data, q_pop_data;
   logic [QCOUNT_W-1:0] q_count;
   logic [MAG_W-1:0]    magnitude;

   assign csr_ready = 1'b1;

   prewitt_front #(
      .MAX_LINE_LENGTH(MAX_LINE_LENGTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_tuser),
      .req_red    (req_tdata[CHANNEL_W-1:0]),
      .req_green  (req_tdata[2*CHANNEL_W-1:CHANNEL_W]),
      .req_blue   (req_tdata[3*CHANNEL_W-1:2*CHANNEL_W]),
      .q_count    (q_count),
      .q_push     (q_push),
      .q_push_data(q_push_data)
   );

   prewitt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_push_data),
      .pop      (q_pop),
      .pop_data (q_pop_data),
      .empty    (q_empty),
      .count    (q_count)
   );

   prewitt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_data       (q_pop_data),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_magnitude(magnitude),
      .rsp_frame_end(rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_W'(magnitude);

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_count < QCOUNT_W'(QUEUE_DEPTH)) || q_pop)
      else $error("gradient queue overflow");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty gradient queue");

   a_magnitude_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (magnitude <= MAG_W'(MAG_MAX)))
      else $error("magnitude out of range");

endmodule
